### design/four_class_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// four class priority queue assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef FOUR_CLASS_PRIORITY_QUEUE_ASSERT_SVH
`define FOUR_CLASS_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FCPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcpq same-cycle check failed");

// next-cycle implication
`define FCPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcpq next-cycle check failed");

// delayed implication
`define FCPQ_ASSERT_TWO(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("fcpq two-cycle check failed");

`else

`define FCPQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define FCPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`define FCPQ_ASSERT_TWO(label, clk, rst, ante, cons)

`endif

`endif

### design/fcpq_pkg.sv
// ----------------------------------------------------------------------------
// fcpq_pkg
// shared types and constants of the four class priority queue
// ----------------------------------------------------------------------------
package fcpq_pkg;

   localparam int NUM_CLASSES = 4;
   localparam int FIELD_BITS  = 16;

   // request codes
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } req_op_type;

   // priority classes, labels R O Y G
   typedef enum logic [1:0] {
      CLASS_RED    = 2'd0,
      CLASS_ORANGE = 2'd1,
      CLASS_YELLOW = 2'd2,
      CLASS_GREEN  = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // store access command from control to entry store
   typedef struct packed {
      logic      wr;
      logic      rd;
      class_type cls;
   } mem_cmd_type;

   // registered result information
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       removed;
      class_type  cls;
   } rsp_info_type;

endpackage

### design/fcpq_store.sv
// ----------------------------------------------------------------------------
// fcpq_store
// entry memory, one circular region per class, registered read port
// ----------------------------------------------------------------------------
module fcpq_store
   import fcpq_pkg::*;
#(
   parameter int CLASS_DEPTH = 16,
   parameter int PTR_BITS    = 4,
   parameter int DATA_BITS   = 32
) (
   input  logic                 clock,
   input  mem_cmd_type          mem_cmd,
   input  logic [PTR_BITS-1:0]  mem_ptr,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [NUM_CLASSES][CLASS_DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr) begin
         mem[mem_cmd.cls][mem_ptr] <= wr_data;
      end
      if (mem_cmd.rd) begin
         rd_data_ff <= mem[mem_cmd.cls][mem_ptr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fcpq_ctrl.sv
// ----------------------------------------------------------------------------
// fcpq_ctrl
// per-class pointers and fill counts, priority pick and result status
// ----------------------------------------------------------------------------
module fcpq_ctrl
   import fcpq_pkg::*;
#(
   parameter int CLASS_DEPTH = 16,
   parameter int PTR_BITS    = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  req_op_type          op,
   input  class_type           cls,
   output mem_cmd_type         mem_cmd,
   output logic [PTR_BITS-1:0] mem_ptr,
   output rsp_info_type        rsp_info
);

   localparam int FILL_BITS = $clog2(CLASS_DEPTH + 1);
   localparam logic [FILL_BITS-1:0] FULL_COUNT = FILL_BITS'(CLASS_DEPTH);
   localparam logic [PTR_BITS-1:0]  LAST_PTR   = PTR_BITS'(CLASS_DEPTH - 1);

   logic [PTR_BITS-1:0]  rd_ptr_ff [NUM_CLASSES];
   logic [PTR_BITS-1:0]  rd_ptr_in [NUM_CLASSES];
   logic [PTR_BITS-1:0]  wr_ptr_ff [NUM_CLASSES];
   logic [PTR_BITS-1:0]  wr_ptr_in [NUM_CLASSES];
   logic [FILL_BITS-1:0] fill_ff   [NUM_CLASSES];
   logic [FILL_BITS-1:0] fill_in   [NUM_CLASSES];

   logic [NUM_CLASSES-1:0] nonempty;
   logic [NUM_CLASSES-1:0] full;
   logic [NUM_CLASSES-1:0] ins_hit;
   logic [NUM_CLASSES-1:0] rem_hit;
   logic                   ins_req;
   logic                   rem_req;
   logic                   taken;
   logic                   sel_full;
   logic [1:0]             rem_cls;
   logic [PTR_BITS-1:0]    ptr_sel;
   rsp_info_type           rsp_ff;
   rsp_info_type           rsp_in;

   function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] p);
      next_slot = (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      ins_req  = item_valid && (op == OP_INSERT);
      rem_req  = item_valid && (op == OP_REMOVE);
      taken    = 1'b0;
      sel_full = 1'b0;
      rem_cls  = '0;
      ptr_sel  = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         nonempty[c] = (fill_ff[c] != '0);
         full[c]     = (fill_ff[c] == FULL_COUNT);
         if (cls == class_type'(c) && full[c]) begin
            sel_full = 1'b1;
         end
         ins_hit[c] = ins_req && (cls == class_type'(c)) && !full[c];
         // lowest-numbered non-empty class wins, so red first
         rem_hit[c] = rem_req && nonempty[c] && !taken;
         taken      = taken || nonempty[c];
         if (ins_hit[c]) begin
            ptr_sel = ptr_sel | wr_ptr_ff[c];
         end
         if (rem_hit[c]) begin
            ptr_sel = ptr_sel | rd_ptr_ff[c];
            rem_cls = rem_cls | 2'(c);
         end
         wr_ptr_in[c] = ins_hit[c] ? next_slot(wr_ptr_ff[c]) : wr_ptr_ff[c];
         rd_ptr_in[c] = rem_hit[c] ? next_slot(rd_ptr_ff[c]) : rd_ptr_ff[c];
         if (ins_hit[c]) begin
            fill_in[c] = fill_ff[c] + 1'b1;
         end else if (rem_hit[c]) begin
            fill_in[c] = fill_ff[c] - 1'b1;
         end else begin
            fill_in[c] = fill_ff[c];
         end
      end

      mem_cmd.wr  = |ins_hit;
      mem_cmd.rd  = |rem_hit;
      mem_cmd.cls = (op == OP_INSERT) ? cls : class_type'(rem_cls);
      mem_ptr     = ptr_sel;

      rsp_in.valid   = item_valid;
      rsp_in.removed = |rem_hit;
      rsp_in.cls     = (|rem_hit) ? class_type'(rem_cls) : CLASS_RED;
      if (op == OP_INSERT) begin
         rsp_in.status = sel_full ? STATUS_FULL : STATUS_OK;
      end else begin
         rsp_in.status = (|nonempty) ? STATUS_OK : STATUS_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            rd_ptr_ff[c] <= '0;
            wr_ptr_ff[c] <= '0;
            fill_ff[c]   <= '0;
         end
         rsp_ff.valid <= 1'b0;
      end else begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            rd_ptr_ff[c] <= rd_ptr_in[c];
            wr_ptr_ff[c] <= wr_ptr_in[c];
            fill_ff[c]   <= fill_in[c];
         end
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.status  <= rsp_in.status;
      rsp_ff.removed <= rsp_in.removed;
      rsp_ff.cls     <= rsp_in.cls;
   end

   assign rsp_info = rsp_ff;

endmodule

### design/four_class_priority_queue.sv
// ----------------------------------------------------------------------------
// four_class_priority_queue
// strict priority queue, classes red orange yellow green, fifo within a class
// ----------------------------------------------------------------------------
//
//   channel   handshake         payload
//   -------   ---------------   ---------------------------------------------
//   request   start / busy      req_type req_pkg_class req_arrival_time
//                               req_service_time
//   result    rsp_valid strobe  rsp_status rsp_out_class rsp_out_arrival
//                               rsp_out_service
//
// one request is taken in every cycle while busy is low; its result strobes
// after the transfer passes the input register, then the pointer update and
// store access into the result and read-data registers
// busy is high only while reset is held; reset clears pointers, fill counts
// and the valid flags, the entry store itself is not cleared
// results cannot be held off, each is shown for a single cycle
//
module four_class_priority_queue
   import fcpq_pkg::*;
#(
   parameter int CLASS_DEPTH = 16,
   parameter int TIME_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_type,
   input  logic [1:0]            req_pkg_class,
   input  logic [FIELD_BITS-1:0] req_arrival_time,
   input  logic [FIELD_BITS-1:0] req_service_time,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [1:0]            rsp_out_class,
   output logic [FIELD_BITS-1:0] rsp_out_arrival,
   output logic [FIELD_BITS-1:0] rsp_out_service
);

`include "four_class_priority_queue_assert.svh"

   // only the low time bits are kept, and at most a port's width survives
   localparam int STORE_BITS = (TIME_BITS < FIELD_BITS) ? TIME_BITS : FIELD_BITS;
   localparam int DATA_BITS  = 2 * STORE_BITS;
   localparam int PTR_BITS   = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;

   // input register
   logic                  item_valid_ff;
   req_op_type            op_ff;
   class_type             cls_ff;
   logic [FIELD_BITS-1:0] arrival_ff;
   logic [FIELD_BITS-1:0] service_ff;

   mem_cmd_type           mem_cmd;
   logic [PTR_BITS-1:0]   mem_ptr;
   logic [DATA_BITS-1:0]  wr_data;
   logic [DATA_BITS-1:0]  rd_data;
   rsp_info_type          rsp_info;
   logic                  req_transfer;

   assign busy         = reset;
   assign req_transfer = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= req_transfer;
      end
      op_ff      <= req_op_type'(req_type);
      cls_ff     <= class_type'(req_pkg_class);
      arrival_ff <= req_arrival_time;
      service_ff <= req_service_time;
   end

   // packed entry: service above arrival
   assign wr_data = {service_ff[STORE_BITS-1:0], arrival_ff[STORE_BITS-1:0]};

   fcpq_ctrl #(
      .CLASS_DEPTH (CLASS_DEPTH),
      .PTR_BITS    (PTR_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .op         (op_ff),
      .cls        (cls_ff),
      .mem_cmd    (mem_cmd),
      .mem_ptr    (mem_ptr),
      .rsp_info   (rsp_info)
   );

   fcpq_store #(
      .CLASS_DEPTH (CLASS_DEPTH),
      .PTR_BITS    (PTR_BITS),
      .DATA_BITS   (DATA_BITS)
   ) u_store (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .mem_ptr (mem_ptr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // result fields; only a successful remove carries a package
   always_comb begin
      rsp_valid       = rsp_info.valid;
      rsp_status      = rsp_info.status;
      rsp_out_class   = rsp_info.cls;
      rsp_out_arrival = '0;
      rsp_out_service = '0;
      if (rsp_info.removed) begin
         rsp_out_arrival[STORE_BITS-1:0] = rd_data[STORE_BITS-1:0];
         rsp_out_service[STORE_BITS-1:0] = rd_data[DATA_BITS-1:STORE_BITS];
      end
   end

   // every request transfer is followed by its result strobe
   `FCPQ_ASSERT_TWO(a_result_follows, clock, reset, req_transfer, rsp_valid)
   // an entry is either written or read, never both in one cycle
   `FCPQ_ASSERT_SAME(a_store_one_access, clock, reset, mem_cmd.wr, !mem_cmd.rd)
   // a store read always turns into a successful remove result
   `FCPQ_ASSERT_NEXT(a_read_gives_ok, clock, reset, mem_cmd.rd,
                     rsp_valid && rsp_info.removed && rsp_status == STATUS_OK)

endmodule
